@@ rtl/core/cwsa_pkg.sv @@
// shared types for the column weighted sliding average
package cwsa_pkg;

    localparam int CHAN_W   = 8;
    localparam int WGT_W    = 3;
    localparam int GAIN_W   = 10;
    localparam int QUOT_W   = 8;
    localparam int WGT_MAX  = 7;
    localparam int GAIN_RST = 128;

    typedef struct packed {
        logic [CHAN_W-1:0] pix_red;
        logic [CHAN_W-1:0] pix_green;
        logic [CHAN_W-1:0] pix_blue;
        logic              column_start;
    } t_cwsa_pix_in;

    typedef struct packed {
        logic [CHAN_W-1:0] avg_red;
        logic [CHAN_W-1:0] avg_green;
        logic [CHAN_W-1:0] avg_blue;
    } t_cwsa_pix_out;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [WGT_W-1:0]  wgt;
    } t_cwsa_entry;

endpackage

@@ rtl/core/column_weighted_sliding_average.sv @@
// top level of the column weighted sliding average
//
//  channel | handshake                | word
//  --------+--------------------------+----------------------------------------
//  in      | i_in_valid / o_in_stall  | i_in_word  (pixel and column start)
//  out     | o_out_valid / i_out_stall| o_out_word (averaged pixel)
//  cfg     | i_cfg_valid / o_cfg_ready| i_cfg_data (gain divisor)
//
// a priming word passes the ring read, then the read-modify-write of the sums
// a primed word then also passes the 8-step divider and the output register
// one word is processed at a time; the ring memory read is registered
// reset clears sums, fill count and ring position; the ring itself is not cleared
// a stalled output holds the result register; the next word is taken once it is loaded
module column_weighted_sliding_average
    import cwsa_pkg::*;
#(
    parameter int WINDOW = 96
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_cwsa_pix_in        i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_cwsa_pix_out       o_out_word,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [GAIN_W-1:0]   i_cfg_data
);

    localparam int SUM_W  = $clog2(WINDOW*255*WGT_MAX+1);
    localparam int TOT_W  = $clog2(WINDOW*WGT_MAX+2);
    localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W = $clog2(WINDOW+1);
    localparam int PROD_W = CHAN_W + WGT_W;
    localparam int CSUM_W = CHAN_W + 2;
    localparam int KD_W   = GAIN_W + WGT_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_UPD   = 6'b000100,
        S_START = 6'b001000,
        S_DIV   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state             r_state, n_state;
    t_cwsa_pix_in       r_in;
    logic [GAIN_W-1:0]  r_gain;
    logic [SUM_W-1:0]   r_sum_red, r_sum_green, r_sum_blue;
    logic [TOT_W-1:0]   r_total;
    logic [POS_W-1:0]   r_pos;
    logic [FILL_W-1:0]  r_fill;
    logic [WGT_W-1:0]   r_wgt;
    logic               r_out_valid;
    t_cwsa_pix_out      r_out_word;

    t_cwsa_entry        r_ring [WINDOW];
    t_cwsa_entry        r_rd_data;
    t_cwsa_entry        w_wr_data;

    logic               w_accept;
    logic               w_primed;
    logic               w_out_free;
    logic [CSUM_W-1:0]  w_csum;
    logic [GAIN_W-1:0]  w_gain_eff;
    logic [WGT_MAX-1:0] w_ge;
    logic [WGT_W:0]     w_cnt;
    logic [WGT_W-1:0]   w_wgt;
    logic [PROD_W-1:0]  w_add_r, w_add_g, w_add_b;
    logic [PROD_W-1:0]  w_sub_r, w_sub_g, w_sub_b;
    logic [WGT_W-1:0]   w_sub_w;
    logic               w_div_busy;
    t_cwsa_pix_out      w_quot;

    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_primed    = (r_fill == FILL_W'(WINDOW));
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // weight: channel sum over divisor plus one, saturated
    always_comb begin
        w_csum     = CSUM_W'(r_in.pix_red) + CSUM_W'(r_in.pix_green)
                   + CSUM_W'(r_in.pix_blue);
        w_gain_eff = (r_gain == '0) ? GAIN_W'(1) : r_gain;
        for (int k = 1; k <= WGT_MAX; k++) begin
            w_ge[k-1] = (KD_W'(k) * KD_W'(w_gain_eff)) <= KD_W'(w_csum);
        end
        w_cnt = (WGT_W+1)'($countones(w_ge));
        w_wgt = (w_cnt >= (WGT_W+1)'(WGT_MAX)) ? WGT_W'(WGT_MAX) : WGT_W'(w_cnt + 1'b1);
    end

    // read-modify-write terms
    always_comb begin
        w_add_r = PROD_W'(r_in.pix_red)   * PROD_W'(r_wgt);
        w_add_g = PROD_W'(r_in.pix_green) * PROD_W'(r_wgt);
        w_add_b = PROD_W'(r_in.pix_blue)  * PROD_W'(r_wgt);
        w_sub_r = '0;
        w_sub_g = '0;
        w_sub_b = '0;
        w_sub_w = '0;
        if (w_primed) begin
            w_sub_r = PROD_W'(r_rd_data.red)   * PROD_W'(r_rd_data.wgt);
            w_sub_g = PROD_W'(r_rd_data.green) * PROD_W'(r_rd_data.wgt);
            w_sub_b = PROD_W'(r_rd_data.blue)  * PROD_W'(r_rd_data.wgt);
            w_sub_w = r_rd_data.wgt;
        end
        w_wr_data = '{red: r_in.pix_red, green: r_in.pix_green,
                      blue: r_in.pix_blue, wgt: r_wgt};
    end

    // ring memory
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_rd_data <= r_ring[r_pos];
        end
        if (r_state == S_UPD) begin
            r_ring[r_pos] <= w_wr_data;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept) n_state = S_READ;
            S_READ:  n_state = S_UPD;
            S_UPD:   n_state = w_primed ? S_START : S_IDLE;
            S_START: n_state = S_DIV;
            S_DIV:   if (!w_div_busy) n_state = S_OUT;
            S_OUT:   if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gain      <= GAIN_W'(GAIN_RST);
            r_sum_red   <= '0;
            r_sum_green <= '0;
            r_sum_blue  <= '0;
            r_total     <= TOT_W'(1);
            r_pos       <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_gain <= i_cfg_data;
            end
            if (w_accept && i_in_word.column_start) begin
                r_sum_red   <= '0;
                r_sum_green <= '0;
                r_sum_blue  <= '0;
                r_total     <= TOT_W'(1);
                r_pos       <= '0;
                r_fill      <= '0;
            end
            if (r_state == S_UPD) begin
                r_sum_red   <= r_sum_red   + SUM_W'(w_add_r) - SUM_W'(w_sub_r);
                r_sum_green <= r_sum_green + SUM_W'(w_add_g) - SUM_W'(w_sub_g);
                r_sum_blue  <= r_sum_blue  + SUM_W'(w_add_b) - SUM_W'(w_sub_b);
                r_total     <= r_total + TOT_W'(r_wgt) - TOT_W'(w_sub_w);
                r_pos       <= (r_pos == POS_W'(WINDOW - 1)) ? '0 : r_pos + 1'b1;
                if (!w_primed) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (r_state == S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_word;
        end
        if (r_state == S_READ) begin
            r_wgt <= w_wgt;
        end
        if (r_state == S_OUT && w_out_free) begin
            r_out_word <= w_quot;
        end
    end

    cwsa_div #(
        .WINDOW (WINDOW)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_state == S_START),
        .i_sum_red   (r_sum_red),
        .i_sum_green (r_sum_green),
        .i_sum_blue  (r_sum_blue),
        .i_total     (r_total),
        .o_busy      (w_div_busy),
        .o_quot      (w_quot)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

@@ rtl/core/cwsa_div.sv @@
// three-lane restoring divider, one quotient bit per cycle, shared divisor
module cwsa_div
    import cwsa_pkg::*;
#(
    parameter int WINDOW = 96
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_start,
    input  logic [$clog2(WINDOW*255*WGT_MAX+1)-1:0]      i_sum_red,
    input  logic [$clog2(WINDOW*255*WGT_MAX+1)-1:0]      i_sum_green,
    input  logic [$clog2(WINDOW*255*WGT_MAX+1)-1:0]      i_sum_blue,
    input  logic [$clog2(WINDOW*WGT_MAX+2)-1:0]          i_total,
    output logic                                         o_busy,
    output t_cwsa_pix_out                                o_quot
);

    localparam int SUM_W = $clog2(WINDOW*255*WGT_MAX+1);
    localparam int TOT_W = $clog2(WINDOW*WGT_MAX+2);
    localparam int DW    = (SUM_W > TOT_W + QUOT_W) ? SUM_W : TOT_W + QUOT_W;
    localparam int CNT_W = $clog2(QUOT_W);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [TOT_W-1:0]  r_div;
    logic [DW-1:0]     r_rem [3];
    logic [QUOT_W-1:0] r_q   [3];
    logic [DW-1:0]     w_trial;
    logic [DW-1:0]     n_rem [3];
    logic [2:0]        w_bit;

    always_comb begin
        w_trial = DW'(r_div) << r_cnt;
        for (int c = 0; c < 3; c++) begin
            w_bit[c] = (r_rem[c] >= w_trial);
            n_rem[c] = w_bit[c] ? (r_rem[c] - w_trial) : r_rem[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(QUOT_W - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div    <= i_total;
            r_rem[0] <= DW'(i_sum_red);
            r_rem[1] <= DW'(i_sum_green);
            r_rem[2] <= DW'(i_sum_blue);
        end else if (r_busy) begin
            for (int c = 0; c < 3; c++) begin
                r_rem[c] <= n_rem[c];
                r_q[c]   <= {r_q[c][QUOT_W-2:0], w_bit[c]};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = '{avg_red: r_q[0], avg_green: r_q[1], avg_blue: r_q[2]};

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// self-checking testbench for column_weighted_sliding_average with its own window average tracker
module tb_top;
    import cwsa_pkg::*;

    localparam int WINDOW_LEN    = 96;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 135;
    localparam int SETTLE_CYCLES = 40;
    localparam int QUIET_LIMIT   = 3000;
    localparam int HOLD_AT       = 400;
    localparam int HOLD_CYCLES   = 300;
    localparam int CALM_FROM     = 650;
    localparam int CALM_TO       = 900;
    localparam int IDLE_PCT      = 7;

    class window_tracker;
        bit [CHAN_W-1:0] red_ring [WINDOW_LEN];
        bit [CHAN_W-1:0] green_ring [WINDOW_LEN];
        bit [CHAN_W-1:0] blue_ring [WINDOW_LEN];
        bit [WGT_W-1:0]  wgt_ring [WINDOW_LEN];
        int unsigned     red_acc, green_acc, blue_acc, wgt_acc;
        int unsigned     slot, filled;
        bit [GAIN_W-1:0] gain;
        t_cwsa_pix_out   pending_avgs[$];
        int unsigned     checked, errors, starts;

        function new();
            gain    = GAIN_W'(GAIN_RST);
            checked = 0;
            errors  = 0;
            starts  = 0;
            restart();
        endfunction

        function void restart();
            red_acc   = 0;
            green_acc = 0;
            blue_acc  = 0;
            wgt_acc   = 1;
            slot      = 0;
            filled    = 0;
        endfunction

        function void take_pixel(t_cwsa_pix_in px);
            int unsigned   r, g, b, div, w;
            bit            primed;
            t_cwsa_pix_out avg;
            r = px.pix_red;
            g = px.pix_green;
            b = px.pix_blue;
            if (px.column_start) begin
                restart();
                starts++;
            end
            if (slot >= WINDOW_LEN) slot = 0;
            primed = (filled >= WINDOW_LEN);
            if (primed) begin
                red_acc   -= red_ring[slot] * wgt_ring[slot];
                green_acc -= green_ring[slot] * wgt_ring[slot];
                blue_acc  -= blue_ring[slot] * wgt_ring[slot];
                wgt_acc   -= wgt_ring[slot];
            end
            div = (gain == 0) ? 1 : gain;
            w   = (r + g + b) / div + 1;
            if (w > WGT_MAX) w = WGT_MAX;
            red_ring[slot]   = CHAN_W'(r);
            green_ring[slot] = CHAN_W'(g);
            blue_ring[slot]  = CHAN_W'(b);
            wgt_ring[slot]   = WGT_W'(w);
            red_acc   += r * w;
            green_acc += g * w;
            blue_acc  += b * w;
            wgt_acc   += w;
            slot = (slot + 1 >= WINDOW_LEN) ? 0 : slot + 1;
            if (!primed) begin
                filled++;
                return;
            end
            avg.avg_red   = CHAN_W'(red_acc / wgt_acc);
            avg.avg_green = CHAN_W'(green_acc / wgt_acc);
            avg.avg_blue  = CHAN_W'(blue_acc / wgt_acc);
            pending_avgs.push_back(avg);
        endfunction

        function void match_average(t_cwsa_pix_out got);
            t_cwsa_pix_out want;
            if (pending_avgs.size() == 0) begin
                $error("averaged pixel %h arrived with none expected", got);
                errors++;
                return;
            end
            want = pending_avgs.pop_front();
            checked++;
            if (got.avg_red !== want.avg_red) begin
                $error("avg_red expected %0d actual %0d", want.avg_red, got.avg_red);
                errors++;
            end
            if (got.avg_green !== want.avg_green) begin
                $error("avg_green expected %0d actual %0d", want.avg_green, got.avg_green);
                errors++;
            end
            if (got.avg_blue !== want.avg_blue) begin
                $error("avg_blue expected %0d actual %0d", want.avg_blue, got.avg_blue);
                errors++;
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    t_cwsa_pix_in      in_word;
    logic              out_valid;
    logic              out_stall;
    t_cwsa_pix_out     out_word;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [GAIN_W-1:0] cfg_data;

    window_tracker tracker = new();
    int unsigned   pix_sent = 0;
    int unsigned   gains_written = 0;
    int unsigned   quiet_cycles = 0;
    logic          calm;

    assign calm = (pix_sent >= CALM_FROM) && (pix_sent < CALM_TO);

    column_weighted_sliding_average #(
        .WINDOW(WINDOW_LEN)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_word (out_word),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic t_cwsa_pix_in pix(int r, int g, int b, bit cs);
        t_cwsa_pix_in px;
        px.pix_red      = CHAN_W'(r);
        px.pix_green    = CHAN_W'(g);
        px.pix_blue     = CHAN_W'(b);
        px.column_start = cs;
        return px;
    endfunction

    function automatic int random_chan();
        if ($urandom_range(3) == 0) return $urandom_range(1) ? 255 : 0;
        return $urandom_range(255);
    endfunction

    task automatic send_pixel(input t_cwsa_pix_in px);
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            do @(posedge clk); while (!calm && $urandom_range(99) < IDLE_PCT);
        end
        in_valid <= 1'b1;
        in_word  <= px;
        do @(posedge clk); while (in_stall);
        tracker.take_pixel(px);
        pix_sent++;
    endtask

    task automatic write_gain(input logic [GAIN_W-1:0] g);
        cfg_valid <= 1'b1;
        cfg_data  <= g;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        tracker.gain = g;
        gains_written++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.pending_avgs.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // output side: random stalls, one long hold to back up the input
    initial begin : receiver
        int unsigned hold_left;
        bit          held;
        hold_left = 0;
        held      = 1'b0;
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (!held && pix_sent >= HOLD_AT) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) tracker.match_average(out_word);
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        t_cwsa_pix_in directed[$];
        int           gain_plan [PHASES];
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_word   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        gain_plan = '{GAIN_RST, 1023, 768, 1, 0, 200, 128, 0};
        gain_plan[PHASES-1] = $urandom_range(1023, 128);
        directed = '{
            pix(0, 0, 0, 0), pix(255, 255, 255, 0), pix(255, 0, 0, 0), pix(0, 255, 0, 0),
            pix(0, 0, 255, 0), pix(170, 85, 170, 0), pix(85, 170, 85, 0), pix(1, 1, 1, 0),
            pix(254, 254, 254, 0), pix(128, 127, 128, 0), pix(255, 255, 255, 1),
            pix(0, 0, 0, 0), pix(255, 0, 255, 0), pix(0, 255, 0, 0), pix(128, 128, 128, 0),
            pix(127, 127, 127, 0), pix(200, 10, 90, 0), pix(255, 255, 254, 0),
            pix(0, 0, 1, 0), pix(128, 0, 0, 1), pix(64, 32, 16, 0), pix(255, 255, 255, 0)
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset gain, priming from reset state, restarts while priming
        foreach (directed[i]) send_pixel(directed[i]);

        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                settle();
                write_gain(GAIN_W'(gain_plan[p]));
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_pixel(pix(random_chan(), random_chan(), random_chan(),
                               $urandom_range(199) == 0));
        end
        settle();

        $display("run covered %0d pixels, %0d averages checked, %0d column starts",
                 pix_sent, tracker.checked, tracker.starts);
        $display("gain written %0d times (0, 1, 128, 768, 1023 among them), one long output hold",
                 gains_written);
        if (tracker.errors == 0 && tracker.pending_avgs.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
